// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the UART transceiver RTL. The macros expand to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge out of reset
`define UHD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define UHD_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UHD_ASSERT(lbl, clk, rst_n, prop, msg)
`define UHD_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== sv/uhd_pkg.sv =====
// ---------------------------------------------------------------------------
// uhd_pkg
// Types, register indexes and constants of the half-duplex UART transceiver.
// ---------------------------------------------------------------------------
package uhd_pkg;

	// default receive FIFO depth (holds one byte less than this)
	localparam int UHD_FIFO_DEPTH = 64;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_DATA_BITS    = 3'd0,
		CFG_PARITY_MODE  = 3'd1,
		CFG_STOP_BITS    = 3'd2,
		CFG_INVERT_LINE  = 3'd3,
		CFG_DRIVE_ALWAYS = 3'd4,
		CFG_BIT_PERIOD   = 3'd5,
		CFG_LISTEN       = 3'd6
	} cfg_idx_t;

	// parity mode codes
	localparam logic [1:0] PAR_ODD  = 2'd1;
	localparam logic [1:0] PAR_EVEN = 2'd2;

	// read status codes
	typedef enum logic [1:0] {
		RD_OK        = 2'd0,
		RD_EMPTY     = 2'd1,
		RD_NO_LISTEN = 2'd2
	} rd_status_t;

	// transmitter state
	typedef enum logic [3:0] {
		TX_IDLE  = 4'b0001,
		TX_FRAME = 4'b0010,
		TX_BREAK = 4'b0100,
		TX_TRAIL = 4'b1000
	} tx_mode_t;

	// effective configuration, already saturated to legal values
	typedef struct packed {
		logic [3:0]  data_bits;
		logic        parity_en;
		logic        parity_odd;
		logic        stop2;
		logic        invert;
		logic        drive_always;
		logic [15:0] period;
		logic        listen;
	} cfg_t;

	// input word
	typedef struct packed {
		logic       rx_level;
		logic       send_valid;
		logic [7:0] send_data;
		logic       break_valid;
		logic       read_req;
		logic       peek_req;
		logic       flush_req;
	} in_t;

	// result word
	typedef struct packed {
		logic       tx_level;
		logic       tx_drive;
		logic       tx_busy;
		logic       read_valid;
		logic [7:0] read_data;
		rd_status_t read_status;
		logic [5:0] fill_count;
		logic       overflow;
	} out_t;

	// transmitter to top and receiver
	typedef struct packed {
		logic level;
		logic drive;
		logic busy;
		logic sending_next;
	} tx_out_t;

	// receiver / FIFO to top
	typedef struct packed {
		logic       read_valid;
		logic [7:0] read_data;
		rd_status_t read_status;
		logic [5:0] fill_count;
		logic       overflow;
	} rx_out_t;

endpackage

// ===== sv/uhd_ram.sv =====
// ---------------------------------------------------------------------------
// uhd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module uhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/uhd_tx.sv =====
// ---------------------------------------------------------------------------
// uhd_tx
// Transmitter: frame and break shift register with bit timing counter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uhd_tx import uhd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  cfg_t    cfg,
	input  in_t     item,
	output tx_out_t txo
);

	tx_mode_t    mode_q, mode_l, mode_d;
	logic [15:0] phase_q, phase_l, phase_d, phase_inc;
	logic [3:0]  idx_q, idx_l, idx_d, idx_dec;
	logic [11:0] shift_q, shift_l, shift_d, frame;
	logic [3:0]  stop_n, frame_len, brk_len;
	logic [7:0]  data_m;
	logic        pb, level_b;
	logic        sending_q;

	// frame image: start, data LSB first, parity, stop bits
	always_comb begin
		stop_n    = cfg.stop2 ? 4'd2 : 4'd1;
		frame_len = 4'd1 + cfg.data_bits + {3'b000, cfg.parity_en} + stop_n;
		brk_len   = cfg.data_bits + stop_n + 4'd1;
		for (int i = 0; i < 8; i++) begin
			data_m[i] = item.send_data[i] & (4'(i) < cfg.data_bits);
		end
		pb = cfg.parity_odd ? ~(^data_m) : ^data_m;
		for (int k = 0; k < 12; k++) begin
			if (k == 0) begin
				frame[k] = 1'b0;
			end else if (4'(k) <= cfg.data_bits) begin
				frame[k] = data_m[3'(k - 1)];
			end else if (cfg.parity_en && 4'(k) == cfg.data_bits + 4'd1) begin
				frame[k] = pb;
			end else begin
				frame[k] = 4'(k) < frame_len;
			end
		end
	end

	// load, drive and advance
	always_comb begin
		mode_l  = mode_q;
		shift_l = shift_q;
		idx_l   = idx_q;
		phase_l = phase_q;
		if (mode_q == TX_IDLE) begin
			if (item.send_valid) begin
				mode_l  = TX_FRAME;
				shift_l = frame;
				idx_l   = frame_len;
				phase_l = '0;
			end else if (item.break_valid) begin
				mode_l  = TX_BREAK;
				shift_l = '0;
				idx_l   = brk_len;
				phase_l = '0;
			end
		end

		level_b   = 1'b1;
		txo.drive = cfg.drive_always;
		txo.busy  = 1'b0;
		case (mode_l)
			TX_FRAME, TX_BREAK: begin
				level_b   = shift_l[0];
				txo.drive = 1'b1;
				txo.busy  = 1'b1;
			end
			TX_TRAIL: begin
				txo.busy = 1'b1;
			end
			default: ;
		endcase
		txo.level = level_b ^ cfg.invert;

		mode_d    = mode_l;
		shift_d   = shift_l;
		idx_d     = idx_l;
		phase_d   = phase_l;
		phase_inc = phase_l + 16'd1;
		idx_dec   = (idx_l != 4'd0) ? idx_l - 4'd1 : 4'd0;
		if (mode_l != TX_IDLE) begin
			if (phase_inc >= cfg.period) begin
				phase_d = '0;
				if (mode_l == TX_TRAIL) begin
					mode_d = TX_IDLE;
				end else begin
					shift_d = shift_l >> 1;
					idx_d   = idx_dec;
					if (idx_dec == 4'd0) begin
						mode_d = TX_TRAIL;
					end
				end
			end else begin
				phase_d = phase_inc;
			end
		end
		txo.sending_next = (mode_d == TX_FRAME) || (mode_d == TX_BREAK);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= TX_IDLE;
			shift_q <= '0;
			idx_q   <= '0;
			phase_q <= '0;
		end else if (adv) begin
			mode_q  <= mode_d;
			shift_q <= shift_d;
			idx_q   <= idx_d;
			phase_q <= phase_d;
		end
	end

	assign sending_q = (mode_q == TX_FRAME) || (mode_q == TX_BREAK);

	// a frame or break in flight always has bits left
	`UHD_NEVER(a_tx_idx, clk, arst_n, sending_q && idx_q == 4'd0, "sending with no bits left")

endmodule

// ===== sv/uhd_rx.sv =====
// ---------------------------------------------------------------------------
// uhd_rx
// Receiver: start detect, mid-bit sampling, ring FIFO with read, peek and
// flush, sticky overflow.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uhd_rx import uhd_pkg::*; #(
	parameter int FIFO_DEPTH = UHD_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  logic    cfg_clear,
	input  cfg_t    cfg,
	input  in_t     item,
	input  logic    tx_sending,
	output rx_out_t rxo
);

	localparam int AW     = $clog2(FIFO_DEPTH);
	localparam int LAST_I = FIFO_DEPTH - 1;
	localparam logic [AW-1:0] LAST    = LAST_I[AW-1:0];
	localparam logic [AW:0]   DEPTH_V = FIFO_DEPTH[AW:0];

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	logic [AW-1:0] head_q, tail_q, head_f, tail_f, head_n, tail_n, head_d, nx;
	logic          ovf_q, ovf_n;
	logic [15:0]   phase_q, phase_n, ph, target;
	logic [3:0]    idx_q, idx_n, idx_inc, stop_n, limit;
	logic [7:0]    shift_q, shift_n, ram_q, byp_data_q, head_data;
	logic          active_q, active_n, prev_q, byp_q, cur, req;
	logic          ram_we;
	logic [AW:0]   cnt;

	assign head_data = byp_q ? byp_data_q : ram_q;

	// host side, then receiver
	always_comb begin
		req             = item.read_req | item.peek_req;
		head_f          = head_q;
		tail_f          = tail_q;
		rxo.read_valid  = 1'b0;
		rxo.read_data   = '0;
		rxo.read_status = RD_OK;
		if (req) begin
			if (!cfg.listen) begin
				rxo.read_status = RD_NO_LISTEN;
			end else if (head_q == tail_q) begin
				rxo.read_status = RD_EMPTY;
			end else begin
				rxo.read_valid = 1'b1;
				rxo.read_data  = head_data;
				if (item.read_req) begin
					head_f = nxt(head_q);
				end
			end
		end
		if (item.flush_req && cfg.listen) begin
			head_f = '0;
			tail_f = '0;
		end

		cur      = item.rx_level ^ cfg.invert;
		stop_n   = cfg.stop2 ? 4'd2 : 4'd1;
		limit    = cfg.data_bits + {3'b000, cfg.parity_en} + stop_n;
		target   = (idx_q == 4'd0) ? {1'b0, cfg.period[15:1]} : cfg.period;
		ph       = phase_q + 16'd1;
		idx_inc  = idx_q + 4'd1;
		nx       = nxt(tail_f);
		head_n   = head_f;
		tail_n   = tail_f;
		ovf_n    = ovf_q;
		phase_n  = phase_q;
		idx_n    = idx_q;
		shift_n  = shift_q;
		active_n = active_q;
		ram_we   = 1'b0;
		if (!cfg.listen || tx_sending) begin
			active_n = 1'b0;
			idx_n    = '0;
			phase_n  = '0;
		end else if (!active_q) begin
			if (prev_q && !cur) begin
				active_n = 1'b1;
				phase_n  = '0;
				idx_n    = '0;
				shift_n  = '0;
			end
		end else if (ph >= target) begin
			phase_n = '0;
			if (idx_q == 4'd0) begin
				idx_n = 4'd1;
			end else begin
				if (idx_q <= cfg.data_bits) begin
					shift_n[3'(idx_q - 4'd1)] = shift_q[3'(idx_q - 4'd1)] | cur;
				end
				idx_n = idx_inc;
				if (idx_inc > limit) begin
					if (nx != head_f) begin
						ram_we = 1'b1;
						tail_n = nx;
					end else begin
						ovf_n = 1'b1;
					end
					active_n = 1'b0;
					idx_n    = '0;
				end
			end
		end else begin
			phase_n = ph;
		end

		// fill level after this word
		if (tail_n >= head_n) begin
			cnt = {1'b0, tail_n} - {1'b0, head_n};
		end else begin
			cnt = {1'b0, tail_n} + DEPTH_V - {1'b0, head_n};
		end
		rxo.fill_count = 6'(cnt);
		rxo.overflow   = ovf_n;
	end

	// head address for next cycle's prefetch
	always_comb begin
		if (cfg_clear) begin
			head_d = '0;
		end else if (adv) begin
			head_d = head_n;
		end else begin
			head_d = head_q;
		end
	end

	// FIFO storage
	uhd_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we & adv),
		.waddr(tail_f),
		.wdata(shift_n),
		.raddr(head_d),
		.rdata(ram_q)
	);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			ovf_q      <= 1'b0;
			phase_q    <= '0;
			idx_q      <= '0;
			shift_q    <= '0;
			active_q   <= 1'b0;
			prev_q     <= 1'b1;
			byp_q      <= 1'b0;
			byp_data_q <= '0;
		end else begin
			// write to the prefetched entry: forward it
			byp_q      <= ram_we && adv && (tail_f == head_d);
			byp_data_q <= shift_n;
			if (cfg_clear) begin
				head_q <= '0;
				tail_q <= '0;
				ovf_q  <= 1'b0;
			end else if (adv) begin
				head_q <= head_n;
				tail_q <= tail_n;
				ovf_q  <= ovf_n;
			end
			if (adv) begin
				phase_q  <= phase_n;
				idx_q    <= idx_n;
				shift_q  <= shift_n;
				active_q <= active_n;
				prev_q   <= cur;
			end
		end
	end

	// a stored byte leaves the FIFO non-empty
	`UHD_ASSERT(a_rx_push, clk, arst_n, (ram_we && adv) |=> head_q != tail_q, "push left FIFO empty")

endmodule

// ===== sv/uart_half_duplex_with_rx_fifo_top.sv =====
// ---------------------------------------------------------------------------
// uart_half_duplex_with_rx_fifo_top
// Half-duplex UART transceiver with a receive ring FIFO, one word per tick.
// ---------------------------------------------------------------------------
// Each input word is one bit-timing tick. While the output is not stalled a
// word is taken every clock cycle: it lands in an input register, the
// transmitter, FIFO logic and receiver work on it in one pass, and its
// result is loaded into an output register, from which it is offered, so
// the block keeps a steady rate of one word per cycle. A stalled output
// holds the input register, which then stalls the input in the same cycle.
// The FIFO storage is a RAM with registered read; the head entry is
// prefetched from the next head address so reads and peeks return in the
// same tick. It holds FIFO_DEPTH-1 bytes and needs no clearing pass after
// reset. Configuration is to be written by the user through a plain write
// port only while no word is in flight; the block itself does not enforce it.
`include "assert_macros.svh"

module uart_half_duplex_with_rx_fifo_top import uhd_pkg::*; #(
	parameter int FIFO_DEPTH = UHD_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [3:0]  data_bits_q;
	logic [1:0]  parity_q, stop_q;
	logic        invert_q, drive_q, listen_q;
	logic [15:0] period_q;
	cfg_t        cfg;
	logic        cfg_clear;

	logic        valid_s1, out_valid_q, advance;
	in_t         item_s1;
	out_t        out_data_q, out_d;
	tx_out_t     txo;
	rx_out_t     rxo;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= 4'd8;
			parity_q    <= 2'd0;
			stop_q      <= 2'd1;
			invert_q    <= 1'b0;
			drive_q     <= 1'b1;
			period_q    <= 16'd16;
			listen_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DATA_BITS:    data_bits_q <= cfg_data[3:0];
				CFG_PARITY_MODE:  parity_q    <= cfg_data[1:0];
				CFG_STOP_BITS:    stop_q      <= cfg_data[1:0];
				CFG_INVERT_LINE:  invert_q    <= cfg_data[0];
				CFG_DRIVE_ALWAYS: drive_q     <= cfg_data[0];
				CFG_BIT_PERIOD:   period_q    <= cfg_data;
				CFG_LISTEN:       listen_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// listen turning on empties the FIFO and clears overflow
	assign cfg_clear = cfg_we && (cfg_index == CFG_LISTEN) && !listen_q && cfg_data[0];

	// effective settings
	always_comb begin
		if (data_bits_q < 4'd5) begin
			cfg.data_bits = 4'd5;
		end else if (data_bits_q > 4'd8) begin
			cfg.data_bits = 4'd8;
		end else begin
			cfg.data_bits = data_bits_q;
		end
		cfg.parity_en    = (parity_q == PAR_ODD) || (parity_q == PAR_EVEN);
		cfg.parity_odd   = parity_q == PAR_ODD;
		cfg.stop2        = stop_q >= 2'd2;
		cfg.invert       = invert_q;
		cfg.drive_always = drive_q;
		cfg.period       = (period_q == 16'd0) ? 16'd1 : period_q;
		cfg.listen       = listen_q;
	end

	// handshake: word moves from input register to output register
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q <= out_d;
		end
	end

	uhd_tx u_tx (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (advance),
		.cfg   (cfg),
		.item  (item_s1),
		.txo   (txo)
	);

	uhd_rx #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (advance),
		.cfg_clear (cfg_clear),
		.cfg       (cfg),
		.item      (item_s1),
		.tx_sending(txo.sending_next),
		.rxo       (rxo)
	);

	// result word
	always_comb begin
		out_d.tx_level    = txo.level;
		out_d.tx_drive    = txo.drive;
		out_d.tx_busy     = txo.busy;
		out_d.read_valid  = rxo.read_valid;
		out_d.read_data   = rxo.read_data;
		out_d.read_status = rxo.read_status;
		out_d.fill_count  = rxo.fill_count;
		out_d.overflow    = rxo.overflow;
	end

	// a processed word always reaches the output register
	`UHD_ASSERT(a_adv_out, clk, arst_n, advance |=> out_valid_q, "processed word not presented")
	// a held word stays in the input register unchanged
	`UHD_ASSERT(a_s1_hold, clk, arst_n, in_stall |=> (valid_s1 && $stable(item_s1)), "held word lost")

endmodule
